// ===== src/dsq_pkg.sv =====
// ============================================================================
// dsq_pkg
// Shared types and constants for the delta-coded sleep queue.
// ============================================================================
package dsq_pkg;

    // command carried on the input beat
    typedef enum logic [1:0] {
        CMD_SLEEP = 2'd0,
        CMD_WAKE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // result status carried on the output beat
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_WOKEN = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    // operation of the shared arithmetic unit
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // one result beat
    typedef struct packed {
        logic [7:0] woken_id;
        t_status    status;
        logic       last;
    } t_result;

    // most threads released by one wake command
    localparam logic [4:0] MAX_RESULTS = 5'd16;

endpackage

// ===== src/dsq_alu.sv =====
// ============================================================================
// dsq_alu
// Shared add/subtract unit with a deadline compare and a zero test.
// ============================================================================
module dsq_alu
    import dsq_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  t_alu_op              i_op,
    input  logic [TIME_BITS-1:0] i_a,
    input  logic [TIME_BITS-1:0] i_b,
    input  logic [TIME_BITS-1:0] i_cmp,
    output logic [TIME_BITS-1:0] o_res,
    output logic                 o_lt,
    output logic                 o_a_zero
);

    // wrapping add or subtract
    always_comb begin
        case (i_op)
            ALU_SUB: o_res = i_a - i_b;
            default: o_res = i_a + i_b;
        endcase
    end

    // deadline falls before the running sum
    assign o_lt     = (i_cmp < o_res);
    assign o_a_zero = (i_a == '0);

endmodule

// ===== src/dsq_ctrl.sv =====
// ============================================================================
// dsq_ctrl
// Sequencer for the sleep queue: circular entry memory, scan, shift,
// insert, tick and wake, all through one shared arithmetic unit.
// ============================================================================
module dsq_ctrl
    import dsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_thread_id,
    input  logic [31:0] i_duration,
    input  logic        i_out_free,
    output logic        o_emit,
    output t_result     o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = TIME_BITS + 8;
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_SCAN_RD = 13'b0000000000010,
        S_SCAN_EV = 13'b0000000000100,
        S_NDIFF   = 13'b0000000001000,
        S_SH_RD   = 13'b0000000010000,
        S_SH_WR   = 13'b0000000100000,
        S_INS     = 13'b0000001000000,
        S_TK_RD   = 13'b0000010000000,
        S_TK_EV   = 13'b0000100000000,
        S_WK_RD   = 13'b0001000000000,
        S_WK_EV   = 13'b0010000000000,
        S_WK_END  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    // logical queue position to memory address, head based ring
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_j, n_j;
    logic [4:0]          r_k, n_k;
    logic [TIME_BITS-1:0] r_sum, n_sum;
    logic [TIME_BITS-1:0] r_nd, n_nd;
    logic [TIME_BITS-1:0] r_dur, n_dur;
    logic [7:0]          r_id, n_id;
    t_status             r_status, n_status;
    logic                r_pend, n_pend;
    logic [7:0]          r_pend_id, n_pend_id;

    // entry memory, one word per sleeper: id above delta
    logic [WW-1:0]       r_mem [QUEUE_DEPTH];
    logic [WW-1:0]       r_rd_word;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [WW-1:0]       wr_word;

    logic [7:0]          rid;
    logic [TIME_BITS-1:0] rdelta;
    logic [AW-1:0]       count_a;
    logic [AW-1:0]       jm1;

    t_alu_op             alu_op;
    logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
    logic                alu_lt, alu_a_zero;

    assign rid     = r_rd_word[WW-1:TIME_BITS];
    assign rdelta  = r_rd_word[TIME_BITS-1:0];
    assign count_a = r_count[AW-1:0];
    assign jm1     = r_j - AW'(1);

    assign o_in_ready = (r_state == S_IDLE);

    // memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    // operand select for the shared unit
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = rdelta;
        alu_b  = r_sum;
        unique case (r_state)
            S_NDIFF: begin
                alu_op = ALU_SUB;
                alu_a  = r_dur;
                alu_b  = r_sum;
            end
            S_SH_WR: begin
                alu_op = ALU_SUB;
                alu_b  = r_nd;
            end
            S_TK_EV: begin
                alu_op = ALU_SUB;
                alu_b  = TIME_BITS'(1);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    dsq_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_cmp    (r_dur),
        .o_res    (alu_res),
        .o_lt     (alu_lt),
        .o_a_zero (alu_a_zero)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_i       = r_i;
        n_pos     = r_pos;
        n_j       = r_j;
        n_k       = r_k;
        n_sum     = r_sum;
        n_nd      = r_nd;
        n_dur     = r_dur;
        n_id      = r_id;
        n_status  = r_status;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        rd_en     = 1'b0;
        rd_addr   = r_head;
        wr_en     = 1'b0;
        wr_addr   = r_head;
        wr_word   = {r_id, r_nd};
        o_emit    = 1'b0;
        o_result  = '{woken_id: 8'd0, status: r_status, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_id     = i_thread_id;
                    n_dur    = TIME_BITS'(i_duration);
                    n_status = ST_DONE;
                    unique case (i_cmd)
                        CMD_SLEEP: begin
                            n_i   = '0;
                            n_sum = '0;
                            n_pos = '0;
                            if (r_count == DEPTH_C) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_NDIFF;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_WAKE: begin
                            n_k     = '0;
                            n_pend  = 1'b0;
                            n_state = S_WK_RD;
                        end
                        CMD_TICK: begin
                            n_state = (r_count == '0) ? S_DONE : S_TK_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // walk the running sum until the deadline falls before it
            S_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = f_phys(r_head, r_i);
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (alu_lt) begin
                    n_pos   = r_i;
                    n_state = S_NDIFF;
                end else begin
                    n_sum = alu_res;
                    if (CW'(r_i) + CW'(1) == r_count) begin
                        n_pos   = count_a;
                        n_state = S_NDIFF;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            // delta of the new entry against the one before it
            S_NDIFF: begin
                n_nd    = alu_res;
                n_j     = count_a;
                n_state = (r_pos == count_a) ? S_INS : S_SH_RD;
            end
            // move entries one place toward the tail, last one first
            S_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = f_phys(r_head, jm1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = f_phys(r_head, r_j);
                wr_word = {rid, (jm1 == r_pos) ? alu_res : rdelta};
                n_j     = jm1;
                n_state = (jm1 == r_pos) ? S_INS : S_SH_RD;
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = f_phys(r_head, r_pos);
                wr_word = {r_id, r_nd};
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            // saturating decrement of the head delta
            S_TK_RD: begin
                rd_en   = 1'b1;
                n_state = S_TK_EV;
            end
            S_TK_EV: begin
                if (!alu_a_zero) begin
                    wr_en   = 1'b1;
                    wr_word = {rid, alu_res};
                end
                n_state = S_DONE;
            end
            // pop ready heads, one result held back to mark the last beat
            S_WK_RD: begin
                if (r_k == MAX_RESULTS || r_count == '0) begin
                    n_state = S_WK_END;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_WK_EV;
                end
            end
            S_WK_EV: begin
                if (alu_a_zero) begin
                    if (!r_pend || i_out_free) begin
                        o_emit    = r_pend;
                        o_result  = '{woken_id: r_pend_id, status: ST_WOKEN, last: 1'b0};
                        n_pend    = 1'b1;
                        n_pend_id = rid;
                        n_head    = f_phys(r_head, AW'(1));
                        n_count   = r_count - CW'(1);
                        n_k       = r_k + 5'd1;
                        n_state   = S_WK_RD;
                    end
                end else begin
                    n_state = S_WK_END;
                end
            end
            S_WK_END: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (r_pend) begin
                        o_result = '{woken_id: r_pend_id, status: ST_WOKEN, last: 1'b1};
                    end else begin
                        o_result = '{woken_id: 8'd0, status: ST_NONE, last: 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_pos     <= n_pos;
        r_j       <= n_j;
        r_k       <= n_k;
        r_sum     <= n_sum;
        r_nd      <= n_nd;
        r_dur     <= n_dur;
        r_id      <= n_id;
        r_status  <= n_status;
        r_pend    <= n_pend;
        r_pend_id <= n_pend_id;
    end

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < DEPTH_S)
        else $error("head pointer out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("sleeper count above depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free)
        else $error("result issued into a busy output register");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the queue by one");

    a_wake_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WK_RD) |-> (r_k <= MAX_RESULTS))
        else $error("wake released too many threads");

endmodule

// ===== src/delta_sleep_queue_top.sv =====
// ============================================================================
// delta_sleep_queue_top
// Ordered queue of sleeping thread ids with delta-coded deadlines.
// ============================================================================
// Input beats (s side) carry a command on tuser: sleep, wake or tick. A
// sleep beat inserts thread_id after every sleeper due at or before its
// duration; if the queue is full the beat is dropped with a full status.
// A tick lowers the head delta by one, stopping at zero. A wake releases
// up to 16 sleepers whose remaining time is zero, one result beat each,
// tlast on the final one, or a single none-ready beat.
// Output beats (m side): woken id on tdata, status on tuser, tlast.
// One command is taken at a time; tready is low while it is worked on.
// A sleep reads and weighs each scanned entry in turn, then reads and
// rewrites each entry it moves, then writes the new entry; a tick reads
// and rewrites the head; a wake reads and pops each released thread in
// turn. Each command ends in the done or wake-end state; then the idle
// state takes the next beat. The single-ported entry memory with a
// registered read and the one shared adder set this step order.
// Results leave through an output register; a stalled receiver holds the
// sequencer at its next result. Reset empties the queue at once.
// ============================================================================
module delta_sleep_queue_top
    import dsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // thread_id[7:0], duration[39:8]
    input  logic [1:0]  i_s_tuser,   // cmd[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // woken_id[7:0]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    output logic        o_m_tlast
);

    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    emit;
    t_result result;

    assign out_free = !r_out_valid || i_m_tready;

    dsq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_cmd       (t_cmd'(i_s_tuser)),
        .i_thread_id (i_s_tdata[7:0]),
        .i_duration  (i_s_tdata[39:8]),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_result    (result)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.woken_id;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

endmodule

// ===== tb/delta_sleep_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// delta_sleep_queue_top_tb
// Self-checking bench for the delta-coded sleep queue.
// ============================================================================
// Drives sleep, wake, tick and unused command beats into the block and keeps
// its own copy of the queue (ids, deltas, fill count) to work out which
// result beats each command must produce. Every output beat is checked in
// order against the oldest pending result. A short directed run covers the
// empty queue, a full queue with an overflowing sleep, a wake that releases
// all sixteen sleepers and a tick on the widest duration. Random traffic
// follows in four phases of sender gaps and receiver stalls.
// ============================================================================
module delta_sleep_queue_top_tb;
    import dsq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int TIME_BITS     = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 80;
    localparam int MAX_REPORTED  = 10;
    localparam int PHASE_ITEMS   = 87;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // thread_id[7:0], duration[39:8]
    logic [1:0]  i_s_tuser;   // cmd[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // woken_id[7:0]
    logic [1:0]  o_m_tuser;   // status[1:0]
    logic        o_m_tlast;

    // shadow copy of the sleep queue
    logic [7:0]  slot_ids    [QUEUE_DEPTH];
    logic [31:0] slot_deltas [QUEUE_DEPTH];
    int          slot_count;

    // result beats still owed by the block, oldest first
    t_result     pending_results[$];

    int          mismatches;
    int          idle_cycles;
    int          src_idle_pct;
    int          sink_stall_pct;

    delta_sleep_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void owe_result(input logic [7:0] id, input t_status st,
                                       input logic last_beat);
        t_result r;
        r.woken_id = id;
        r.status   = st;
        r.last     = last_beat;
        pending_results.push_back(r);
    endfunction

    // remove the head sleeper and close the gap
    function automatic void drop_head_sleeper();
        for (int i = 0; i + 1 < slot_count; i++) begin
            slot_ids[i]    = slot_ids[i + 1];
            slot_deltas[i] = slot_deltas[i + 1];
        end
        slot_count--;
    endfunction

    // update the shadow queue for one accepted command and queue its results
    function automatic void predict_command(input t_cmd cmd, input logic [7:0] id,
                                            input logic [31:0] dur);
        int          pos;
        int          released;
        logic        found;
        logic [31:0] run_sum;
        logic [31:0] prior_sum;
        logic [31:0] new_delta;
        pos      = slot_count;
        released = 0;
        found    = 1'b0;
        run_sum  = '0;
        prior_sum = '0;
        case (cmd)
            CMD_SLEEP: begin
                if (slot_count >= QUEUE_DEPTH) begin
                    owe_result(8'd0, ST_FULL, 1'b1);
                end else begin
                    // place after every sleeper due at or before this deadline
                    for (int i = 0; i < slot_count; i++) begin
                        if (!found) begin
                            run_sum = run_sum + slot_deltas[i];
                            if (dur < run_sum) begin
                                pos   = i;
                                found = 1'b1;
                            end else begin
                                prior_sum = run_sum;
                            end
                        end
                    end
                    new_delta = dur - prior_sum;
                    for (int i = slot_count; i > pos; i--) begin
                        slot_ids[i]    = slot_ids[i - 1];
                        slot_deltas[i] = slot_deltas[i - 1];
                    end
                    slot_ids[pos]    = id;
                    slot_deltas[pos] = new_delta;
                    if (pos + 1 <= slot_count)
                        slot_deltas[pos + 1] = slot_deltas[pos + 1] - new_delta;
                    slot_count++;
                    owe_result(8'd0, ST_DONE, 1'b1);
                end
            end
            CMD_WAKE: begin
                while (released < int'(MAX_RESULTS) && slot_count > 0 &&
                       slot_deltas[0] == 32'd0) begin
                    owe_result(slot_ids[0], ST_WOKEN, 1'b0);
                    drop_head_sleeper();
                    released++;
                end
                if (released == 0)
                    owe_result(8'd0, ST_NONE, 1'b1);
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            CMD_TICK: begin
                // head delta counts down and stops at zero
                if (slot_count > 0 && slot_deltas[0] != 32'd0)
                    slot_deltas[0] = slot_deltas[0] - 32'd1;
                owe_result(8'd0, ST_DONE, 1'b1);
            end
            default: begin
                owe_result(8'd0, ST_DONE, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("mismatch: %s", what);
    endtask

    // send one command beat, with random gaps before it
    task automatic send_command(input t_cmd cmd, input logic [7:0] id,
                                input logic [31:0] dur);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {dur, id};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predict_command(cmd, id, dur);
    endtask

    // hold off the sender until every owed result beat has come out
    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // wake, tick and unused command on an empty queue
    task automatic test_empty_queue();
        send_command(CMD_WAKE, 8'd0, 32'd0);
        send_command(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_NOP, 8'h5A, 32'h1234_5678);
    endtask

    // sixteen sleepers due now, one dropped, then a wake that frees them all
    task automatic test_fill_and_overflow();
        logic [7:0] id;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (k == 0)
                id = 8'h00;
            else if (k == QUEUE_DEPTH - 1)
                id = 8'hFF;
            else
                id = 8'($urandom_range(255));
            send_command(CMD_SLEEP, id, 32'd0);
        end
        send_command(CMD_SLEEP, 8'hA5, 32'hFFFF_FFFF);
        // head delta already zero, tick has nothing to do
        send_command(CMD_TICK, 8'd0, 32'd0);
        wait_for_drain();
        send_command(CMD_WAKE, 8'd0, 32'd0);
    endtask

    // widest duration, one tick off it, nobody ready
    task automatic test_tick_and_none_ready();
        send_command(CMD_SLEEP, 8'($urandom_range(255)), 32'hFFFF_FFFF);
        send_command(CMD_TICK, 8'd0, 32'd0);
        send_command(CMD_WAKE, 8'd0, 32'd0);
        wait_for_drain();
    endtask

    // mixed traffic, mostly short sleeps so ticks make sleepers ready
    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int sink_pct);
        int          pick;
        logic [31:0] dur;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                case ($urandom_range(49))
                    0:       dur = $urandom();
                    1:       dur = 32'hFFFF_FFFF - $urandom_range(3);
                    default: dur = 32'($urandom_range(12));
                endcase
                send_command(CMD_SLEEP, 8'($urandom_range(255)), dur);
            end else if (pick < 72) begin
                send_command(CMD_TICK, 8'($urandom_range(255)), $urandom());
            end else if (pick < 96) begin
                send_command(CMD_WAKE, 8'($urandom_range(255)), $urandom());
            end else begin
                send_command(CMD_NOP, 8'($urandom_range(255)), $urandom());
            end
        end
        wait_for_drain();
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // check each result beat against the oldest owed one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat id=%0d status=%0d last=%0d",
                                          o_m_tdata, o_m_tuser, o_m_tlast));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.woken_id || o_m_tuser !== want.status ||
                    o_m_tlast !== want.last)
                    report_mismatch($sformatf(
                        "exp id=%0d status=%0d last=%0d, got id=%0d status=%0d last=%0d",
                        want.woken_id, want.status, want.last,
                        o_m_tdata, o_m_tuser, o_m_tlast));
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("delta_sleep_queue_top test failed");
            $finish;
        end
    end

    // reset, directed tests, random phases, final verdict
    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = CMD_NOP;
        i_m_tready     = 1'b0;
        slot_count     = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_ids[i]    = '0;
            slot_deltas[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        test_tick_and_none_ready();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 69, 0);
        test_random_traffic(PHASE_ITEMS, 0, 69);
        test_random_traffic(PHASE_ITEMS, 27, 27);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      pending_results.size()));
        if (mismatches == 0)
            $display("delta_sleep_queue_top test passed");
        else
            $display("delta_sleep_queue_top test failed");
        $finish;
    end

endmodule
